[src/brb_pkg.sv]
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Command codes, status codes, default sizes and the transaction structs
// shared by the ring buffer top level and its byte store.
// ----------------------------------------------------------------------------
package brb_pkg;

	// Default number of entries in the byte store.
	localparam int DEPTH_DEF = 1024;
	// Default cap on the bytes returned by one read command.
	localparam int MAX_BURST_DEF = 64;

	// Command codes; codes above CMD_LEVEL are accepted and do nothing.
	typedef enum logic [3:0] {
		CMD_PUSH      = 4'd0,
		CMD_READ      = 4'd1,
		CMD_PUTBACK   = 4'd2,
		CMD_SKIP      = 4'd3,
		CMD_REWIND    = 4'd4,
		CMD_BACKSPACE = 4'd5,
		CMD_SCAN      = 4'd6,
		CMD_READTERM  = 4'd7,
		CMD_LEVEL     = 4'd8
	} cmd_t;

	// Status codes of a result.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_NOTERM = 2'd2;

	// One command transaction.
	typedef struct packed {
		logic [3:0]  cmd;
		logic [7:0]  data;
		logic [7:0]  terminator;
		logic [10:0] count;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]  data_out;
		logic [10:0] length;
		logic [9:0]  level;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

endpackage

[src/brb_store.sv]
// ----------------------------------------------------------------------------
// Byte store
// Single-port-write, single-port-read byte memory with a registered read.
// ----------------------------------------------------------------------------
module brb_store #(
	parameter int DEPTH = brb_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/byte_ring_buffer_with_terminator_scan_unit.sv]
// ----------------------------------------------------------------------------
// Byte ring buffer with terminator scan
// Circular byte queue in one memory, with burst reads, put back, skip,
// rewind, backspace, terminator scan, read to terminator and level query.
// ----------------------------------------------------------------------------
// Push, put back, rewind, backspace and level go through ST_FIN, which registers
//   the result strobe; skip first takes off one DEPTH per step in ST_SKIP.
// Scan: one store read per cycle, until the terminator matches or the head is
//   reached, then the result from ST_FIN.
// A read of n bytes gives one result per cycle, also after the scan of read to
//   terminator. The receiver cannot stall.
// Reset clears the pointers to zero; the store is not cleared, no sweep.
module byte_ring_buffer_with_terminator_scan_unit #(
	parameter int DEPTH     = brb_pkg::DEPTH_DEF,
	parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  brb_pkg::req_t req,
	output logic          busy,
	output logic          strobe,
	output brb_pkg::rsp_t rsp
);

	localparam int PW = $clog2(DEPTH);
	localparam int WW = PW + 12;
	localparam int BW = 7;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SKIP  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_BURST = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t        state_q;
	logic [PW-1:0] wp_q, rp_q, sp_q;
	logic [3:0]    cmd_q;
	logic [7:0]    term_q;
	logic [10:0]   cnt_q;
	logic [WW-1:0] sum_q;
	logic [PW-1:0] scan_p_q;
	logic [PW:0]   scan_idx_q;
	logic          sv_s1;
	logic [PW:0]   sidx_s1;
	logic [BW-1:0] bn_q, bk_q;
	logic [PW-1:0] blvl_q;
	logic [1:0]    st_q;
	logic [10:0]   len_q;
	brb_pkg::rsp_t res_q;
	logic          strobe_q;
	logic          from_mem_q;

	logic          accept;
	logic          empty;
	logic [PW:0]   lvl_raw;
	logic [PW-1:0] lvl_now;
	logic [PW-1:0] wp_nxt, wp_prv, rp_nxt, scan_nxt;
	logic [WW-1:0] rew_d;
	logic [PW-1:0] rew_ptr;
	logic [WW-1:0] lim_w;
	logic [BW-1:0] lim_mb;
	logic [BW-1:0] bn_d;
	logic          match;
	logic          scan_issue;
	logic          we, re;
	logic [PW-1:0] raddr;
	logic [7:0]    rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign empty  = (wp_q == rp_q);

	// Level and pointer steps, modulo DEPTH.
	always_comb begin
		lvl_raw = {1'b0, wp_q} + (PW+1)'(DEPTH) - {1'b0, rp_q};
		if (lvl_raw >= (PW+1)'(DEPTH)) begin
			lvl_raw = lvl_raw - (PW+1)'(DEPTH);
		end
		lvl_now  = lvl_raw[PW-1:0];
		wp_nxt   = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
		wp_prv   = (wp_q == '0) ? PW'(DEPTH - 1) : wp_q - PW'(1);
		rp_nxt   = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
		scan_nxt = (scan_p_q == PW'(DEPTH - 1)) ? '0 : scan_p_q + PW'(1);
	end

	// Rewind target: wraps once below zero and clamps at zero beyond that.
	always_comb begin
		rew_d = WW'(req.count) - WW'(rp_q);
		if (WW'(req.count) <= WW'(rp_q)) begin
			rew_ptr = rp_q - PW'(req.count);
		end else if (rew_d < WW'(DEPTH)) begin
			rew_ptr = PW'(WW'(DEPTH) - rew_d);
		end else begin
			rew_ptr = '0;
		end
	end

	// Burst length: count (or terminator position if less), capped by MAX_BURST and level.
	always_comb begin
		if (state_q == ST_SCAN) begin
			lim_w = (WW'(sidx_s1) < WW'(cnt_q)) ? WW'(sidx_s1) : WW'(cnt_q);
		end else begin
			lim_w = WW'(req.count);
		end
		lim_mb = (lim_w > WW'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(lim_w);
		bn_d   = (WW'(lvl_now) < WW'(lim_mb)) ? BW'(lvl_now) : lim_mb;
	end

	// Store access control.
	assign match      = sv_s1 && (rdata == term_q);
	assign scan_issue = (state_q == ST_SCAN) && !match && (scan_p_q != wp_q);
	assign we         = accept && (req.cmd == brb_pkg::CMD_PUSH);
	assign re         = scan_issue || (state_q == ST_BURST);
	assign raddr      = (state_q == ST_SCAN) ? scan_p_q : rp_q;

	brb_store #(
		.DEPTH (DEPTH),
		.AW    (PW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (req.data),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			rp_q       <= '0;
			sp_q       <= '0;
			cmd_q      <= '0;
			term_q     <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			scan_p_q   <= '0;
			scan_idx_q <= '0;
			sv_s1      <= 1'b0;
			sidx_s1    <= '0;
			bn_q       <= '0;
			bk_q       <= '0;
			blvl_q     <= '0;
			st_q       <= brb_pkg::STAT_OK;
			len_q      <= '0;
			res_q      <= '0;
			strobe_q   <= 1'b0;
			from_mem_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			sv_s1    <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= req.cmd;
						term_q  <= req.terminator;
						cnt_q   <= req.count;
						st_q    <= brb_pkg::STAT_OK;
						len_q   <= '0;
						state_q <= ST_FIN;
						case (req.cmd)
							brb_pkg::CMD_PUSH: begin
								wp_q <= wp_nxt;
							end
							brb_pkg::CMD_READ: begin
								if (empty) begin
									st_q <= brb_pkg::STAT_EMPTY;
								end else begin
									sp_q    <= rp_q;
									bn_q    <= bn_d;
									bk_q    <= '0;
									blvl_q  <= lvl_now - PW'(bn_d);
									state_q <= (bn_d == '0) ? ST_FIN : ST_BURST;
								end
							end
							brb_pkg::CMD_PUTBACK: begin
								rp_q <= sp_q;
							end
							brb_pkg::CMD_SKIP: begin
								sum_q   <= WW'(rp_q) + WW'(req.count);
								state_q <= ST_SKIP;
							end
							brb_pkg::CMD_REWIND: begin
								rp_q <= rew_ptr;
							end
							brb_pkg::CMD_BACKSPACE: begin
								if (!empty) begin
									wp_q <= wp_prv;
								end
							end
							brb_pkg::CMD_SCAN, brb_pkg::CMD_READTERM: begin
								if (empty) begin
									st_q <= brb_pkg::STAT_EMPTY;
								end else begin
									scan_p_q   <= rp_q;
									scan_idx_q <= '0;
									state_q    <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// Reduce tail + count modulo DEPTH one subtraction at a time.
				ST_SKIP: begin
					if (sum_q >= WW'(DEPTH)) begin
						sum_q <= sum_q - WW'(DEPTH);
					end else begin
						rp_q    <= sum_q[PW-1:0];
						state_q <= ST_FIN;
					end
				end
				// Walk the store from the tail, one read a cycle, compare in the cycle after the read.
				ST_SCAN: begin
					if (match) begin
						if (cmd_q == brb_pkg::CMD_SCAN) begin
							len_q   <= 11'(sidx_s1);
							state_q <= ST_FIN;
						end else begin
							sp_q    <= rp_q;
							bn_q    <= bn_d;
							bk_q    <= '0;
							blvl_q  <= lvl_now - PW'(bn_d);
							state_q <= (bn_d == '0) ? ST_FIN : ST_BURST;
						end
					end else if (scan_p_q == wp_q) begin
						st_q    <= brb_pkg::STAT_NOTERM;
						state_q <= ST_FIN;
					end else begin
						scan_p_q   <= scan_nxt;
						scan_idx_q <= scan_idx_q + (PW+1)'(1);
						sv_s1      <= 1'b1;
						sidx_s1    <= scan_idx_q + (PW+1)'(1);
					end
				end
				// One byte per cycle; the read data goes straight to the result.
				ST_BURST: begin
					rp_q              <= rp_nxt;
					bk_q              <= bk_q + BW'(1);
					strobe_q          <= 1'b1;
					from_mem_q        <= 1'b1;
					res_q.data_out    <= '0;
					res_q.length      <= 11'(bk_q + BW'(1));
					res_q.level       <= 10'(blvl_q);
					res_q.status      <= brb_pkg::STAT_OK;
					res_q.last        <= (bk_q + BW'(1) == bn_q);
					if (bk_q + BW'(1) == bn_q) begin
						state_q <= ST_IDLE;
					end
				end
				// Single result carrying the final level.
				ST_FIN: begin
					strobe_q       <= 1'b1;
					from_mem_q     <= 1'b0;
					res_q.data_out <= '0;
					res_q.length   <= len_q;
					res_q.level    <= 10'(lvl_now);
					res_q.status   <= st_q;
					res_q.last     <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result port.
	always_comb begin
		rsp = res_q;
		if (from_mem_q) begin
			rsp.data_out = rdata;
		end
	end
	assign strobe = strobe_q;

	// An accepted transaction makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// The single-result state always emits a final result.
	a_fin_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (strobe && rsp.last))
		else $error("final result missing");

	// A burst never reads past its planned length.
	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BURST) |-> (bk_q < bn_q))
		else $error("burst overran its length");

	// Pointers stay inside the store.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(rp_q) < DEPTH) && (32'(wp_q) < DEPTH) && (32'(sp_q) < DEPTH))
		else $error("pointer out of range");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Byte ring buffer testbench
// Drives command transactions into the ring buffer and predicts every result
// with a behavioral copy of the queue. Each strobed result is checked field
// by field against the oldest prediction. Directed tests come first, then
// random traffic with idle bursts, a pause until drained, and a calm tail.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = brb_pkg::DEPTH_DEF;
	localparam int MAX_BURST = brb_pkg::MAX_BURST_DEF;
	localparam logic [7:0] NEWLINE = 8'h0A;

	logic          clk    = 1'b0;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	brb_pkg::req_t req    = '0;
	logic          busy;
	logic          strobe;
	brb_pkg::rsp_t rsp;

	// Shadow copy of the queue.
	logic [7:0] shadow_bytes [DEPTH];
	bit         was_written [DEPTH];
	logic [9:0] head_ptr  = '0;
	logic [9:0] tail_ptr  = '0;
	logic [9:0] saved_tail = '0;

	brb_pkg::rsp_t pending_results [$];
	int   error_count = 0;
	bit   allow_idle  = 1'b1;

	byte_ring_buffer_with_terminator_scan_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .strobe(strobe), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// Position of the first terminator from the tail, zero when absent.
	function automatic int find_terminator(logic [7:0] term);
		logic [9:0] p;
		int n;
		p = tail_ptr;
		n = 0;
		while (p != head_ptr) begin
			n++;
			if (shadow_bytes[p] == term) return n;
			p++;
		end
		return 0;
	endfunction

	// True when every entry between tail and head holds a written byte.
	function automatic bit tail_region_written();
		logic [9:0] p;
		p = tail_ptr;
		while (p != head_ptr) begin
			if (!was_written[p]) return 1'b0;
			p++;
		end
		return 1'b1;
	endfunction

	// Works out the results of one accepted command and queues them.
	task automatic predict_results(brb_pkg::req_t r);
		brb_pkg::rsp_t out_items [$];
		brb_pkg::rsp_t one;
		logic [1:0] stat;
		logic [10:0] scan_len;
		int want, got, sz;
		stat = brb_pkg::STAT_OK;
		scan_len = '0;
		want = -1;
		case (r.cmd)
			brb_pkg::CMD_PUSH: begin
				shadow_bytes[head_ptr] = r.data;
				was_written[head_ptr] = 1'b1;
				head_ptr++;
			end
			brb_pkg::CMD_READ: begin
				if (tail_ptr == head_ptr) stat = brb_pkg::STAT_EMPTY;
				else want = r.count;
			end
			brb_pkg::CMD_PUTBACK: tail_ptr = saved_tail;
			brb_pkg::CMD_SKIP: tail_ptr = 10'((int'(tail_ptr) + int'(r.count)) % DEPTH);
			brb_pkg::CMD_REWIND: begin
				if (r.count <= tail_ptr) tail_ptr = tail_ptr - 10'(r.count);
				else if (int'(r.count) - int'(tail_ptr) <= DEPTH)
					tail_ptr = 10'((DEPTH - (int'(r.count) - int'(tail_ptr))) % DEPTH);
				else tail_ptr = '0;
			end
			brb_pkg::CMD_BACKSPACE: if (head_ptr != tail_ptr) head_ptr--;
			brb_pkg::CMD_SCAN: begin
				if (tail_ptr == head_ptr) stat = brb_pkg::STAT_EMPTY;
				else begin
					scan_len = 11'(find_terminator(r.terminator));
					if (scan_len == 0) stat = brb_pkg::STAT_NOTERM;
				end
			end
			brb_pkg::CMD_READTERM: begin
				if (tail_ptr == head_ptr) stat = brb_pkg::STAT_EMPTY;
				else begin
					sz = find_terminator(r.terminator);
					if (sz == 0) stat = brb_pkg::STAT_NOTERM;
					else want = (sz > r.count) ? int'(r.count) : sz;
				end
			end
			default: ;
		endcase
		// Burst read: capped, stops when the tail meets the head.
		if (want >= 0) begin
			if (want > MAX_BURST) want = MAX_BURST;
			saved_tail = tail_ptr;
			got = 0;
			while (got < want) begin
				one = '0;
				one.data_out = shadow_bytes[tail_ptr];
				one.length = 11'(got + 1);
				out_items.push_back(one);
				tail_ptr++;
				got++;
				if (tail_ptr == head_ptr) break;
			end
		end
		if (out_items.size() == 0) begin
			one = '0;
			one.length = scan_len;
			out_items.push_back(one);
		end
		foreach (out_items[i]) begin
			out_items[i].level = head_ptr - tail_ptr;
			out_items[i].status = stat;
			out_items[i].last = (i == out_items.size() - 1);
			pending_results.push_back(out_items[i]);
		end
	endtask

	// Sends one command and returns at the edge that accepts it; start stays
	// high so that a following command goes out without a gap.
	task automatic send_command(brb_pkg::req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predict_results(r);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic brb_pkg::req_t make_cmd(brb_pkg::cmd_t c, logic [7:0] d,
			logic [7:0] t, logic [10:0] n);
		brb_pkg::req_t r;
		r.cmd = c;
		r.data = d;
		r.terminator = t;
		r.count = n;
		return r;
	endfunction

	// Checks each strobed result against the oldest prediction.
	always @(posedge clk) begin
		brb_pkg::rsp_t exp_rsp;
		if (strobe) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				error_count++;
			end else begin
				exp_rsp = pending_results.pop_front();
				if (rsp.data_out !== exp_rsp.data_out) begin
					$error("data_out: expected %0d, got %0d", exp_rsp.data_out, rsp.data_out);
					error_count++;
				end
				if (rsp.length !== exp_rsp.length) begin
					$error("length: expected %0d, got %0d", exp_rsp.length, rsp.length);
					error_count++;
				end
				if (rsp.level !== exp_rsp.level) begin
					$error("level: expected %0d, got %0d", exp_rsp.level, rsp.level);
					error_count++;
				end
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
					error_count++;
				end
				if (rsp.last !== exp_rsp.last) begin
					$error("last: expected %0d, got %0d", exp_rsp.last, rsp.last);
					error_count++;
				end
			end
		end
	end

	// Commands on an empty queue, unused codes and backspace with nothing left.
	task automatic test_empty_queue();
		send_command(make_cmd(brb_pkg::CMD_READ, 8'h00, 8'h00, 11'd5));
		send_command(make_cmd(brb_pkg::CMD_READTERM, 8'h00, 8'hFF, 11'd5));
		send_command(make_cmd(brb_pkg::CMD_SCAN, 8'h00, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_BACKSPACE, 8'h00, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_LEVEL, 8'h00, 8'h00, 11'd0));
		send_command(brb_pkg::req_t'({4'hF, 8'hFF, 8'hFF, 11'h7FF}));
		send_command(brb_pkg::req_t'({4'h9, 8'h00, 8'h00, 11'h000}));
	endtask

	// Pushes, a zero-count read, a burst, put back and backspace.
	task automatic test_push_and_read();
		send_command(make_cmd(brb_pkg::CMD_PUSH, 8'h00, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_PUSH, 8'hFF, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_PUSH, 8'h55, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_PUSH, NEWLINE, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_READ, 8'h00, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_READ, 8'h00, 8'h00, 11'h7FF));
		send_command(make_cmd(brb_pkg::CMD_PUTBACK, 8'h00, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_BACKSPACE, 8'h00, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_READ, 8'h00, 8'h00, 11'd2));
	endtask

	// Scan and read to terminator: found, absent and capped to zero.
	task automatic test_terminator();
		send_command(make_cmd(brb_pkg::CMD_PUSH, 8'hAA, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_PUSH, NEWLINE, 8'h00, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_SCAN, 8'h00, NEWLINE, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_SCAN, 8'h00, 8'h7E, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_READTERM, 8'h00, 8'h7E, 11'd9));
		send_command(make_cmd(brb_pkg::CMD_READTERM, 8'h00, NEWLINE, 11'd0));
		send_command(make_cmd(brb_pkg::CMD_READTERM, 8'h00, NEWLINE, 11'h400));
	endtask

	// Skip and rewind with wrap, and a rewind larger than the store.
	task automatic test_pointer_moves();
		send_command(make_cmd(brb_pkg::CMD_REWIND, 8'h00, 8'h00, 11'd1024));
		send_command(make_cmd(brb_pkg::CMD_SKIP, 8'h00, 8'h00, 11'd1024));
		send_command(make_cmd(brb_pkg::CMD_REWIND, 8'h00, 8'h00, 11'h7FF));
		send_command(make_cmd(brb_pkg::CMD_SKIP, 8'h00, 8'h00, 11'h7FF));
		send_command(make_cmd(brb_pkg::CMD_SKIP, 8'h00, 8'h00, 11'(head_ptr - tail_ptr)));
	endtask

	// One random command; a read that would touch never written bytes is
	// replaced by a skip that moves the tail onto the head.
	task automatic send_random_command();
		brb_pkg::req_t r;
		int pick;
		r.data = ($urandom_range(0, 3) == 0) ? NEWLINE : 8'($urandom);
		r.terminator = ($urandom_range(0, 1) == 0) ? NEWLINE : 8'($urandom);
		r.count = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(0, 12));
		pick = $urandom_range(0, 99);
		if (pick < 45) r.cmd = brb_pkg::CMD_PUSH;
		else if (pick < 60) r.cmd = brb_pkg::CMD_READ;
		else if (pick < 70) r.cmd = brb_pkg::CMD_READTERM;
		else if (pick < 78) r.cmd = brb_pkg::CMD_SCAN;
		else if (pick < 83) r.cmd = brb_pkg::CMD_PUTBACK;
		else if (pick < 88) r.cmd = brb_pkg::CMD_SKIP;
		else if (pick < 93) r.cmd = brb_pkg::CMD_REWIND;
		else if (pick < 97) r.cmd = brb_pkg::CMD_BACKSPACE;
		else if (pick < 99) r.cmd = brb_pkg::CMD_LEVEL;
		else r.cmd = brb_pkg::cmd_t'($urandom_range(9, 15));
		if ((r.cmd == brb_pkg::CMD_READ || r.cmd == brb_pkg::CMD_READTERM
				|| r.cmd == brb_pkg::CMD_SCAN) && !tail_region_written()) begin
			r.cmd = brb_pkg::CMD_SKIP;
			r.count = 11'(10'(int'(head_ptr) - int'(tail_ptr)));
		end
		send_command(r);
		if (allow_idle && $urandom_range(0, 4) == 0)
			idle_cycles($urandom_range(1, 8));
	endtask

	task automatic test_random_traffic(int n);
		repeat (n) send_random_command();
	endtask

	// The sender holds off until every outstanding result has arrived.
	task automatic test_drain_pause();
		wait_drained();
		test_random_traffic(20);
	endtask

	// Back to back commands with no idling at all.
	task automatic test_calm_tail();
		allow_idle = 1'b0;
		test_random_traffic(40);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_push_and_read();
		test_terminator();
		test_pointer_moves();
		test_random_traffic(200);
		test_drain_pause();
		test_calm_tail();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
src/brb_pkg.sv
src/brb_store.sv
src/byte_ring_buffer_with_terminator_scan_unit.sv
sim/testbench.sv
